// ===== hw/rtl/sprite_frame_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer assertion macros
// Shared concurrent assertion forms, clocked on i_clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_SEQUENCER_MACROS_SVH
`define SPRITE_FRAME_SEQUENCER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define SFS_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error("sequencer check failed");

// Check a condition in the cycle after its trigger.
`define SFS_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error("sequencer check failed");

`endif

// ===== hw/rtl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Field widths, command and mode codes, register indexes and shared structs.
// ----------------------------------------------------------------------------
package sfs_pkg;

    // Parameter defaults
    localparam int SFS_MAX_FRAMES = 256;
    localparam int SFS_TIME_WIDTH = 32;

    // Field and register widths
    localparam int KIND_W     = 2;
    localparam int ELAPSED_W  = 16;
    localparam int SHOWN_W    = 8;
    localparam int MODE_W     = 3;
    localparam int DELAY_W    = 32;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Item kinds
    localparam t_kind KIND_TICK  = 2'd0;
    localparam t_kind KIND_PAUSE = 2'd1;
    localparam t_kind KIND_STOP  = 2'd2;
    localparam t_kind KIND_START = 2'd3;

    // Playback modes; codes above MODE_REV_LOOP are undefined
    localparam t_mode MODE_LOOP     = 3'd0;
    localparam t_mode MODE_ONCE     = 3'd1;
    localparam t_mode MODE_PINGPONG = 3'd2;
    localparam t_mode MODE_REVERSE  = 3'd3;
    localparam t_mode MODE_REV_LOOP = 3'd4;

    // Configuration register indexes
    localparam t_cfg_idx CFG_MODE  = 2'd0;
    localparam t_cfg_idx CFG_DELAY = 2'd1;
    localparam t_cfg_idx CFG_COUNT = 2'd2;

    // Sequencer status flags
    typedef struct packed {
        logic played;
        logic paused;
        logic stopped;
        logic forward;
    } t_seq_flags;

    // One result beat
    typedef struct packed {
        logic [SHOWN_W-1:0] shown_frame;
        logic               frame_valid;
        logic               finished_once;
        logic               is_paused;
        logic               is_stopped;
        logic               going_forward;
    } t_frame_out;

endpackage

// ===== hw/rtl/sfs_in_if.sv =====
// ----------------------------------------------------------------------------
// Sequencer input channel
// Valid/ready stream carrying one tick or command beat.
// ----------------------------------------------------------------------------
interface sfs_in_if import sfs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [ELAPSED_W-1:0] elapsed;

    modport source (output valid, output kind, output elapsed, input ready);
    modport sink   (input valid, input kind, input elapsed, output ready);
endinterface

// ===== hw/rtl/sfs_out_if.sv =====
// ----------------------------------------------------------------------------
// Sequencer result channel
// Valid/ready stream carrying the displayed frame and status flags.
// ----------------------------------------------------------------------------
interface sfs_out_if import sfs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SHOWN_W-1:0] shown_frame;
    logic               frame_valid;
    logic               finished_once;
    logic               is_paused;
    logic               is_stopped;
    logic               going_forward;

    modport source (output valid, output shown_frame, output frame_valid,
                    output finished_once, output is_paused, output is_stopped,
                    output going_forward, input ready);
    modport sink   (input valid, input shown_frame, input frame_valid,
                    input finished_once, input is_paused, input is_stopped,
                    input going_forward, output ready);
endinterface

// ===== hw/rtl/sfs_display.sv =====
// ----------------------------------------------------------------------------
// Sequencer display mapping
// Maps the raw frame index to the shown index for the mode and packs status.
// ----------------------------------------------------------------------------
module sfs_display import sfs_pkg::*; (
    input  logic [COUNT_W-1:0] i_raw_index,
    input  logic [COUNT_W-1:0] i_count,
    input  t_mode              i_mode,
    input  t_seq_flags         i_flags,
    output t_frame_out         o_frame
);

    logic               w_in_range;
    logic               w_mirrored;
    logic               w_defined;
    logic [COUNT_W-1:0] w_mirror_idx;
    logic [COUNT_W-1:0] w_pick;

    // Pick forward or mirrored index
    always_comb begin
        w_in_range   = i_raw_index < i_count;
        w_mirror_idx = i_count - COUNT_W'(1) - i_raw_index;
        w_mirrored   = 1'b0;
        w_defined    = 1'b1;
        case (i_mode)
            MODE_LOOP:     w_mirrored = 1'b0;
            MODE_ONCE:     w_mirrored = 1'b0;
            MODE_PINGPONG: w_mirrored = !i_flags.forward;
            MODE_REVERSE:  w_mirrored = 1'b1;
            MODE_REV_LOOP: w_mirrored = 1'b1;
            default:       w_defined  = 1'b0;
        endcase
        w_pick = w_mirrored ? w_mirror_idx : i_raw_index;
    end

    // Pack the result; an invalid index shows frame zero
    always_comb begin
        o_frame.frame_valid   = w_defined && w_in_range;
        o_frame.shown_frame   = o_frame.frame_valid ? w_pick[SHOWN_W-1:0] : '0;
        o_frame.finished_once = i_flags.played;
        o_frame.is_paused     = i_flags.paused;
        o_frame.is_stopped    = i_flags.stopped;
        o_frame.going_forward = i_flags.forward;
    end

endmodule

// ===== hw/rtl/sprite_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Steps an animation frame index from time ticks and pause/stop/start commands.
// ----------------------------------------------------------------------------
//  channel    dir  handshake          payload
//  i_item     in   valid/ready        kind, elapsed
//  o_result   out  valid/ready        shown_frame, frame_valid, status flags
//  i_cfg_*    in   write enable only  index, data (mode, delay, count)
//
//  One beat is taken every cycle unless the result stalls; a result beat is
//  offered once its item has moved through the input and result registers.
//  The sequencer state updates as a beat moves from the input register to
//  the result register, so consecutive beats chain without bubbles.
//  A stalled result holds; one more beat waits in the input register.
//  Synchronous active-low reset clears state and loads register defaults.
// ----------------------------------------------------------------------------
`include "sprite_frame_sequencer_macros.svh"

module sprite_frame_sequencer import sfs_pkg::*; #(
    parameter int MAX_FRAMES = SFS_MAX_FRAMES,
    parameter int TIME_WIDTH = SFS_TIME_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sfs_in_if.sink                i_item,
    sfs_out_if.source             o_result
);

    localparam int IDX_W  = (MAX_FRAMES >= (1 << SHOWN_W)) ? SHOWN_W : $clog2(MAX_FRAMES);
    localparam int ACMP_W = (TIME_WIDTH > DELAY_W) ? TIME_WIDTH : DELAY_W;

    // Configuration registers
    t_mode                r_mode;
    logic [DELAY_W-1:0]   r_delay;
    logic [COUNT_W-1:0]   r_count;

    // Sequencer state
    logic [TIME_WIDTH-1:0] r_acc,  n_acc;
    logic [IDX_W-1:0]      r_idx,  n_idx;
    t_seq_flags            r_flags, n_flags;

    // Pipeline registers
    logic                 r_in_v;
    t_kind                r_kind;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic                 r_out_v;
    t_frame_out           r_out;

    logic                  w_adv;
    logic                  w_accept;
    logic [COUNT_W-1:0]    w_cnt;
    logic [TIME_WIDTH:0]   w_sum;
    logic [TIME_WIDTH-1:0] w_sat;
    logic [COUNT_W-1:0]    w_next;
    logic                  w_frozen;
    t_frame_out            w_frame;

    // Handshake: advance when the result slot is free or draining
    assign w_adv        = r_in_v && (!r_out_v || o_result.ready);
    assign i_item.ready = !r_in_v || w_adv;
    assign w_accept     = i_item.valid && i_item.ready;

    // Clamp the frame count to the supported maximum
    assign w_cnt = (int'(r_count) > MAX_FRAMES) ? COUNT_W'(MAX_FRAMES) : r_count;

    // Next sequencer state for the beat in the input register
    always_comb begin
        n_acc    = r_acc;
        n_idx    = r_idx;
        n_flags  = r_flags;
        w_sum    = {1'b0, r_acc} + (TIME_WIDTH + 1)'(r_elapsed);
        w_sat    = w_sum[TIME_WIDTH] ? '1 : w_sum[TIME_WIDTH-1:0];
        w_next   = COUNT_W'(r_idx) + COUNT_W'(1);
        w_frozen = ((r_mode == MODE_ONCE) || (r_mode == MODE_REVERSE)) && r_flags.played;
        case (r_kind)
            KIND_TICK: begin
                if (!w_frozen && !r_flags.paused && !r_flags.stopped) begin
                    n_acc = w_sat;
                    if (ACMP_W'(w_sat) >= ACMP_W'(r_delay)) begin
                        n_acc = '0;
                        if (w_next >= w_cnt) begin
                            n_idx          = '0;
                            n_flags.played = 1'b1;
                            if (r_mode == MODE_PINGPONG) begin
                                n_flags.forward = !r_flags.forward;
                            end
                        end else begin
                            n_idx = w_next[IDX_W-1:0];
                        end
                    end
                end
            end
            KIND_PAUSE: begin
                n_flags.paused = 1'b1;
            end
            KIND_STOP: begin
                if (!r_flags.stopped) begin
                    n_flags.stopped = 1'b1;
                    n_flags.paused  = 1'b0;
                    n_flags.played  = 1'b0;
                    n_flags.forward = 1'b1;
                    n_idx           = '0;
                    n_acc           = '0;
                end
            end
            KIND_START: begin
                n_flags.paused  = 1'b0;
                n_flags.stopped = 1'b0;
            end
            default: begin
                n_flags = r_flags;
            end
        endcase
    end

    // Map the updated index for display
    sfs_display u_display (
        .i_raw_index (COUNT_W'(n_idx)),
        .i_count     (w_cnt),
        .i_mode      (r_mode),
        .i_flags     (n_flags),
        .o_frame     (w_frame)
    );

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_LOOP;
            r_delay <= '0;
            r_count <= COUNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:  r_mode  <= i_cfg_data[MODE_W-1:0];
                CFG_DELAY: r_delay <= i_cfg_data[DELAY_W-1:0];
                CFG_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    // Update state as a beat advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_idx   <= '0;
            r_flags <= '{played: 1'b0, paused: 1'b0, stopped: 1'b0, forward: 1'b1};
        end else if (w_adv) begin
            r_acc   <= n_acc;
            r_idx   <= n_idx;
            r_flags <= n_flags;
        end
    end

    // Hold valid bits for the input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_v <= 1'b1;
            end else if (w_adv) begin
                r_in_v <= 1'b0;
            end
            if (w_adv) begin
                r_out_v <= 1'b1;
            end else if (o_result.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind    <= i_item.kind;
            r_elapsed <= i_item.elapsed;
        end
        if (w_adv) begin
            r_out <= w_frame;
        end
    end

    // Drive the result channel
    assign o_result.valid         = r_out_v;
    assign o_result.shown_frame   = r_out.shown_frame;
    assign o_result.frame_valid   = r_out.frame_valid;
    assign o_result.finished_once = r_out.finished_once;
    assign o_result.is_paused     = r_out.is_paused;
    assign o_result.is_stopped    = r_out.is_stopped;
    assign o_result.going_forward = r_out.going_forward;

    // Checks
    `SFS_ASSERT_NOW(a_shown_in_count, r_out_v && r_out.frame_valid, COUNT_W'(r_out.shown_frame) < w_cnt)
    `SFS_ASSERT_NOW(a_stop_clears, r_flags.stopped, (r_idx == '0) && (r_acc == '0) && !r_flags.played && r_flags.forward)
    `SFS_ASSERT_NEXT(a_adv_fills_out, w_adv, r_out_v)
    `SFS_ASSERT_NEXT(a_stall_holds_in, r_in_v && !w_adv, r_in_v && $stable(r_kind) && $stable(r_elapsed))

endmodule
